[hdl/a2u_pkg.sv]
// ----------------------------------------------------------------------------
// a2u_pkg: shared types and constants for the ASCII to unsigned parser
// Field widths, radix limits and the beat structs that pass between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package a2u_pkg;

	// Field widths
	localparam int VALUE_WIDTH  = 32;
	localparam int OFFSET_WIDTH = 16;
	localparam int BASE_WIDTH   = 6;
	localparam int CHAR_WIDTH   = 8;

	// Radix values
	localparam logic [BASE_WIDTH-1:0] BASE_AUTO  = 6'd0;
	localparam logic [BASE_WIDTH-1:0] BASE_UNARY = 6'd1;
	localparam logic [BASE_WIDTH-1:0] BASE_MIN   = 6'd2;
	localparam logic [BASE_WIDTH-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_WIDTH-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_WIDTH-1:0] BASE_HEX   = 6'd16;
	localparam logic [BASE_WIDTH-1:0] BASE_MAX   = 6'd36;
	localparam logic [BASE_WIDTH-1:0] BASE_RESET = BASE_DEC;

	// One input beat: a character of the string
	typedef struct packed {
		logic [CHAR_WIDTH-1:0] char_code;
		logic                  last_char;
	} in_item_t;

	// One result beat: one converted string
	typedef struct packed {
		logic [VALUE_WIDTH-1:0]  parsed_value;
		logic [OFFSET_WIDTH-1:0] end_offset;
		logic                    overflow_flag;
		logic                    bad_base_flag;
	} out_item_t;

	// Input register contents handed to the parse core
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} s1_beat_t;

	// Result handed from the parse core to the result register
	typedef struct packed {
		logic      valid;
		out_item_t item;
	} res_beat_t;

endpackage

`default_nettype wire

[hdl/a2u_in_stage.sv]
// ----------------------------------------------------------------------------
// a2u_in_stage: input register
// Holds one character beat; stalls upstream only while its beat cannot move.
// ----------------------------------------------------------------------------
`default_nettype none

module a2u_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  a2u_pkg::in_item_t in_data,
	input  logic              s1_take,
	output a2u_pkg::s1_beat_t s1
);
	import a2u_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	// held beat blocks the input only when the core cannot take it
	assign in_stall = valid_s1 && !s1_take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.item  = item_s1;

endmodule

`default_nettype wire

[hdl/a2u_core.sv]
// ----------------------------------------------------------------------------
// a2u_core: per-character parse step
// Phase tracking, radix selection, multiply-add with overflow check and the
// result formatting at the last character of a string.
// ----------------------------------------------------------------------------
`default_nettype none

module a2u_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [a2u_pkg::BASE_WIDTH-1:0]     cfg_data,
	input  a2u_pkg::s1_beat_t                  s1,
	input  logic                               step_en,
	output a2u_pkg::res_beat_t                 res
);
	import a2u_pkg::*;

	// parse phases
	localparam logic [2:0] PH_SPACE   = 3'd0;
	localparam logic [2:0] PH_SUBJECT = 3'd1;
	localparam logic [2:0] PH_ZERO    = 3'd2;
	localparam logic [2:0] PH_HEXWAIT = 3'd3;
	localparam logic [2:0] PH_DIGITS  = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;

	// character codes
	localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_WIDTH-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_WIDTH-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [CHAR_WIDTH-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_WIDTH-1:0] CH_LO_Z  = 8'h7A;
	localparam logic [CHAR_WIDTH-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_WIDTH-1:0] CH_LO_X  = 8'h78;
	localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;

	localparam int PROD_WIDTH = VALUE_WIDTH + BASE_WIDTH + 1;

	// state
	logic [2:0]              phase_q;
	logic                    neg_q;
	logic [BASE_WIDTH-1:0]   base_q;
	logic [VALUE_WIDTH-1:0]  acc_q;
	logic                    ovf_q;
	logic [OFFSET_WIDTH-1:0] pos_q;
	logic [OFFSET_WIDTH-1:0] endp_q;
	logic [BASE_WIDTH-1:0]   nbase_q;

	// next state
	logic [2:0]              phase_n;
	logic                    neg_n;
	logic [BASE_WIDTH-1:0]   base_n;
	logic [VALUE_WIDTH-1:0]  acc_n;
	logic                    ovf_n;
	logic [OFFSET_WIDTH-1:0] endp_n;

	logic                    fire;
	logic                    first;
	logic [BASE_WIDTH-1:0]   base_eff;
	logic                    bad;
	logic [2:0]              phase_eff;
	logic [CHAR_WIDTH-1:0]   c;
	logic [CHAR_WIDTH-1:0]   dig_wide;
	logic [BASE_WIDTH-1:0]   dig;
	logic                    dig_valid;
	logic [BASE_WIDTH-1:0]   try_base;
	logic                    digit_ok;
	logic [PROD_WIDTH-1:0]   prod;
	logic                    prod_ovf;
	logic                    try_go;
	logic [OFFSET_WIDTH-1:0] pos_inc;
	logic [VALUE_WIDTH-1:0]  value;

	assign fire = s1.valid && step_en;
	assign c    = s1.item.char_code;

	// radix sampled at the first character of a string
	assign first     = (pos_q == '0) && (phase_q == PH_SPACE);
	assign base_eff  = first ? nbase_q : base_q;
	assign bad       = (base_eff == BASE_UNARY) || (base_eff > BASE_MAX);
	assign phase_eff = (first && bad) ? PH_DONE : phase_q;

	// saturating position increment
	assign pos_inc = (pos_q == '1) ? pos_q : pos_q + 1'b1;

	// digit value of the character
	always_comb begin
		dig_valid = 1'b1;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			dig_wide = c - CH_ZERO;
		end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
			dig_wide = c - CH_UP_A + 8'd10;
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			dig_wide = c - CH_LO_A + 8'd10;
		end else begin
			dig_wide  = '0;
			dig_valid = 1'b0;
		end
		dig = dig_wide[BASE_WIDTH-1:0];
	end

	// radix for a digit attempt; auto resolves to decimal or octal here
	always_comb begin
		case (phase_eff)
			PH_SPACE, PH_SUBJECT: try_base = (base_eff == BASE_AUTO) ? BASE_DEC : base_eff;
			PH_ZERO:              try_base = (base_eff == BASE_AUTO) ? BASE_OCT : base_eff;
			default:              try_base = base_eff;
		endcase
	end

	// multiply-add; anything above the value width is overflow
	assign digit_ok = dig_valid && (try_base >= BASE_MIN) && (dig < try_base);
	assign prod     = PROD_WIDTH'(acc_q) * PROD_WIDTH'(try_base) + PROD_WIDTH'(dig);
	assign prod_ovf = (prod[PROD_WIDTH-1:VALUE_WIDTH] != '0);

	// phase step
	always_comb begin
		phase_n = phase_eff;
		neg_n   = neg_q;
		base_n  = base_eff;
		acc_n   = acc_q;
		ovf_n   = ovf_q;
		endp_n  = endp_q;
		try_go  = 1'b0;
		case (phase_eff)
			PH_SPACE, PH_SUBJECT: begin
				if (phase_eff == PH_SPACE && (c inside {[CH_TAB:CH_CR], CH_SPACE})) begin
					// leading whitespace: skip
				end else if (phase_eff == PH_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
					neg_n   = (c == CH_MINUS);
					phase_n = PH_SUBJECT;
				end else if ((base_eff == BASE_AUTO || base_eff == BASE_HEX) && c == CH_ZERO) begin
					// possible 0x prefix; the zero already counts as a digit
					acc_n   = '0;
					endp_n  = pos_inc;
					phase_n = PH_ZERO;
				end else begin
					base_n = try_base;
					try_go = 1'b1;
				end
			end
			PH_ZERO: begin
				if (c == CH_LO_X || c == CH_UP_X) begin
					base_n  = BASE_HEX;
					phase_n = PH_HEXWAIT;
				end else begin
					base_n = try_base;
					try_go = 1'b1;
				end
			end
			PH_HEXWAIT, PH_DIGITS: begin
				try_go = 1'b1;
			end
			default: begin
			end
		endcase

		// digit attempt: accumulate or end the number
		if (try_go) begin
			if (!digit_ok) begin
				phase_n = PH_DONE;
			end else begin
				if (ovf_q || prod_ovf) begin
					ovf_n = 1'b1;
				end else begin
					acc_n = prod[VALUE_WIDTH-1:0];
				end
				endp_n  = pos_inc;
				phase_n = PH_DIGITS;
			end
		end
	end

	// result formatting
	always_comb begin
		if (endp_n == '0) begin
			value = '0;
		end else if (ovf_n) begin
			value = '1;
		end else if (neg_n) begin
			value = '0 - acc_n;
		end else begin
			value = acc_n;
		end
		res.valid = fire && s1.item.last_char;
		if (bad) begin
			res.item.parsed_value  = '0;
			res.item.end_offset    = '0;
			res.item.overflow_flag = 1'b0;
			res.item.bad_base_flag = 1'b1;
		end else begin
			res.item.parsed_value  = value;
			res.item.end_offset    = endp_n;
			res.item.overflow_flag = (endp_n != '0) && ovf_n;
			res.item.bad_base_flag = 1'b0;
		end
	end

	// base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbase_q <= BASE_RESET;
		end else if (cfg_we) begin
			nbase_q <= cfg_data;
		end
	end

	// parse state; cleared after the last character of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			base_q  <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			pos_q   <= '0;
			endp_q  <= '0;
		end else if (fire) begin
			if (s1.item.last_char) begin
				phase_q <= PH_SPACE;
				neg_q   <= 1'b0;
				base_q  <= '0;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				pos_q   <= '0;
				endp_q  <= '0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				base_q  <= base_n;
				acc_q   <= acc_n;
				ovf_q   <= ovf_n;
				pos_q   <= pos_inc;
				endp_q  <= endp_n;
			end
		end
	end

	// a result leaves the parser ready for a fresh string
	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> (pos_q == '0) && (phase_q == PH_SPACE) && !ovf_q)
		else $error("parse state not cleared after result");

	// digit phase always has a recorded end
	a_digits_have_end: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DIGITS) |-> (endp_q != '0))
		else $error("digit phase without end position");

	// overflow only follows a converted digit
	a_ovf_has_end: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (endp_q != '0))
		else $error("overflow without converted digit");

endmodule

`default_nettype wire

[hdl/a2u_out_stage.sv]
// ----------------------------------------------------------------------------
// a2u_out_stage: result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module a2u_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  a2u_pkg::res_beat_t res,
	output logic               res_room,
	output logic               out_valid,
	input  logic               out_stall,
	output a2u_pkg::out_item_t out_data
);
	import a2u_pkg::*;

	logic      out_valid_q;
	out_item_t out_data_q;

	// room when empty or being drained this cycle
	assign res_room = !out_valid_q || !out_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_data_q <= res.item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a new result never lands on one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res_room)
		else $error("result overwrites a pending beat");

	// overflow reads as all ones
	a_ovf_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.overflow_flag) |->
		((out_data_q.parsed_value == '1) && !out_data_q.bad_base_flag))
		else $error("overflow result not saturated");

	// bad radix yields an empty conversion
	a_bad_base_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.bad_base_flag) |->
		((out_data_q.parsed_value == '0) && (out_data_q.end_offset == '0)))
		else $error("bad radix result not empty");

endmodule

`default_nettype wire

[hdl/ascii_to_unsigned_parser.sv]
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser: streaming string to unsigned conversion
// Converts a string, one character per beat, into one 32-bit result beat.
//
//   Channel | Direction | Handshake          | Beat contents
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_stall  | char_code, last_char
//   out     | output    | out_valid/out_stall| parsed_value, end_offset, flags
//   cfg     | input     | cfg_valid/cfg_ready| number_base (6 bits)
//
// One character per cycle while in_stall is low; the radix multiply-add of
// the parse core is combinational.
// A result shows on out_valid once the beat carrying last_char has passed
// the input register, the parse core and then the result register.
// Reset clears the parse state and sets the radix register to 10.
// A held result stalls the input only when the next beat ends a string.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_to_unsigned_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  a2u_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output a2u_pkg::out_item_t             out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [a2u_pkg::BASE_WIDTH-1:0] cfg_data
);
	import a2u_pkg::*;

	s1_beat_t  s1;
	res_beat_t res;
	logic      res_room;
	logic      s1_take;

	// radix writes are always taken
	assign cfg_ready = 1'b1;

	// a non-final character never needs the result register
	assign s1_take = !s1.item.last_char || res_room;

	a2u_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.s1_take  (s1_take),
		.s1       (s1)
	);

	a2u_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.s1       (s1),
		.step_en  (s1_take),
		.res      (res)
	);

	a2u_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.res_room  (res_room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
